@@ sv/dexp_pkg.sv @@
// Shared types, constants and the exponential polynomial divisor table for the curve evaluator.
`default_nettype none
package dexp_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned LimW = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned TermN = 9;

  typedef enum logic [CfgIdxW-1:0] {
    REG_C1 = 3'd0, REG_C2 = 3'd1, REG_C3 = 3'd2, REG_C4 = 3'd3,
    REG_C5 = 3'd4, REG_X_MIN = 3'd5, REG_X_MAX = 3'd6, REG_LIMITS = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0, CLAMP_LOW = 2'd1, CLAMP_HIGH = 2'd2
  } clamp_t;

  localparam logic signed [DataW-1:0] Q16Max = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] Q16Min = 32'sh8000_0000;
  localparam logic [DataW-1:0] XMaxReset = 32'h0001_0000;
  localparam logic [LimW-1:0] LimitsReset = 64'h7FFF_FFFF_8000_0000;
  localparam logic signed [31:0] Log2eQ30 = 32'sd1549082005;
  localparam logic [31:0] Ln2Q30 = 32'd744261118;
  localparam logic [30:0] Q30One = 31'h4000_0000;
  localparam logic signed [48:0] ExpArgLimit = 49'sd2097152;

  // Reciprocals of 1..9 scaled by 2^34, rounded up; exact floor for the
  // quotient range used here (numerator below 2^31).
  function automatic logic [34:0] recip(input logic [3:0] n);
    logic [34:0] r;
    r = 35'd0;
    case (n)
      4'd1: r = 35'h4_0000_0000;
      4'd2: r = 35'h2_0000_0000;
      4'd3: r = 35'h1_5555_5556;
      4'd4: r = 35'h1_0000_0000;
      4'd5: r = 35'h0_CCCC_CCCD;
      4'd6: r = 35'h0_AAAA_AAAB;
      4'd7: r = 35'h0_9249_2493;
      4'd8: r = 35'h0_8000_0000;
      4'd9: r = 35'h0_71C7_1C72;
      default: r = 35'd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ sv/dexp_exp.sv @@
// Pipelined fixed-point exponential unit: argument product, range reduction, polynomial, shift.
`default_nettype none
module dexp_exp (
  input  wire logic clk,
  input  wire logic signed [dexp_pkg::DataW-1:0] rate,
  input  wire logic signed [dexp_pkg::DataW-1:0] x,
  output logic signed [dexp_pkg::DataW-1:0] exp_value,
  output logic exp_sat
);
  import dexp_pkg::*;

  localparam int unsigned PolyS = TermN * 3;

  // Stage A: argument product.
  logic signed [48:0] arg_a;
  // Stage B: log2(e) product.
  logic signed [80:0] u_prod;
  logic big_b, tiny_b;
  // Stage C: split and ln2 product.
  logic signed [50:0] k_c;
  logic [47:0] zf_c;
  logic big_c, tiny_c;
  // Polynomial lanes: each term has a multiply, a reciprocal and a sum step.
  logic [31:0] z_l [PolyS+1];
  logic [30:0] p_l [PolyS+1];
  logic [62:0] m_l [PolyS+1];
  logic [65:0] q_l [PolyS+1];
  logic signed [50:0] k_l [PolyS+1];
  logic big_l [PolyS+1];
  logic tiny_l [PolyS+1];

  // Only arguments within +/-32.0 reach the result, and those fit in 23 bits.
  always_ff @(posedge clk) begin
    arg_a <= 49'(($signed(64'(rate)) * $signed(64'(x))) >>> 16);
    u_prod <= 81'($signed(arg_a[22:0])) * 81'(Log2eQ30);
    big_b <= arg_a > ExpArgLimit;
    tiny_b <= arg_a < -ExpArgLimit;
    k_c <= 51'(u_prod >>> 46);
    zf_c <= 48'(u_prod[45:30]) * 48'(Ln2Q30);
    big_c <= big_b;
    tiny_c <= tiny_b;
  end

  assign z_l[0] = zf_c[47:16];
  assign p_l[0] = Q30One;
  assign m_l[0] = '0;
  assign q_l[0] = '0;
  assign k_l[0] = k_c;
  assign big_l[0] = big_c;
  assign tiny_l[0] = tiny_c;

  for (genvar s = 0; s < PolyS; s++) begin : g_poly
    localparam int unsigned Ph = s % 3;
    localparam logic [3:0] Div = 4'(TermN - s / 3);
    always_ff @(posedge clk) begin
      z_l[s+1] <= z_l[s];
      k_l[s+1] <= k_l[s];
      big_l[s+1] <= big_l[s];
      tiny_l[s+1] <= tiny_l[s];
      m_l[s+1] <= (Ph == 0) ? 63'(z_l[s]) * 63'(p_l[s]) : m_l[s];
      q_l[s+1] <= (Ph == 1) ? 66'(m_l[s][62:30]) * 66'(recip(Div)) : q_l[s];
      p_l[s+1] <= (Ph == 2) ? Q30One + 31'(q_l[s][65:34]) : p_l[s];
    end
  end

  logic [30:0] p_end;
  logic signed [50:0] k_end;
  logic [5:0] sh;
  assign p_end = p_l[PolyS];
  assign k_end = k_l[PolyS];
  assign sh = 6'(51'sd14 - k_end);

  always_ff @(posedge clk) begin
    if (big_l[PolyS] || (!tiny_l[PolyS] && k_end >= 51'sd15)) begin
      exp_value <= Q16Max;
      exp_sat <= 1'b1;
    end else if (tiny_l[PolyS] || k_end <= -51'sd48) begin
      exp_value <= '0;
      exp_sat <= 1'b0;
    end else begin
      exp_value <= DataW'(p_end >> sh);
      exp_sat <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ sv/double_exponential_curve_eval_top.sv @@
// Top level of the double exponential curve evaluator pipeline.
`default_nettype none
// Usage: write the eight registers through cfg_we, cfg_index and cfg_data
// while the block is idle. Present a sample on x_sample with start high;
// busy is never raised, so one word is taken every clock cycle.
// Each word gives one result on curve_value, input_clamp, output_clamp and
// saturated, marked by a one-cycle done strobe from the output clamp
// register. There are 35 register stages: the input
// clamp, three for the argument and range reduction, three for each of
// nine polynomial terms, one for the final shift, then the gain product,
// sum and output clamp.
// Throughput is one word per cycle. Reset clears the registers to their
// reset values and empties the pipeline; no result is produced until new
// words arrive. The receiver cannot stall, so results are never held.
module double_exponential_curve_eval_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic signed [dexp_pkg::DataW-1:0] x_sample,
  input  wire logic cfg_we,
  input  wire logic [dexp_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [dexp_pkg::LimW-1:0] cfg_data,
  output logic done,
  output logic signed [dexp_pkg::DataW-1:0] curve_value,
  output logic [1:0] input_clamp,
  output logic [1:0] output_clamp,
  output logic saturated
);
  import dexp_pkg::*;

  localparam int unsigned ExpLat = 3 + TermN * 3 + 1;

  logic signed [DataW-1:0] c1, c2, c3, c4, c5, x_min, x_max;
  logic [LimW-1:0] output_limits;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0; c2 <= '0; c3 <= '0; c4 <= '0; c5 <= '0;
      x_min <= '0; x_max <= XMaxReset; output_limits <= LimitsReset;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_C1: c1 <= cfg_data[DataW-1:0];
        REG_C2: c2 <= cfg_data[DataW-1:0];
        REG_C3: c3 <= cfg_data[DataW-1:0];
        REG_C4: c4 <= cfg_data[DataW-1:0];
        REG_C5: c5 <= cfg_data[DataW-1:0];
        REG_X_MIN: x_min <= cfg_data[DataW-1:0];
        REG_X_MAX: x_max <= cfg_data[DataW-1:0];
        REG_LIMITS: output_limits <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage 0: input clamp.
  logic v0;
  logic signed [DataW-1:0] x0;
  logic [1:0] ic0;
  logic signed [DataW-1:0] x_lo;
  assign x_lo = (x_sample < x_min) ? x_min : x_sample;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= start && !busy;
    if (x_lo > x_max) begin
      x0 <= x_max; ic0 <= CLAMP_HIGH;
    end else begin
      x0 <= x_lo; ic0 <= (x_sample < x_min) ? CLAMP_LOW : CLAMP_NONE;
    end
  end

  logic signed [DataW-1:0] e1, e2;
  logic s1, s2;
  dexp_exp u_exp1 (.clk, .rate(c3), .x(x0), .exp_value(e1), .exp_sat(s1));
  dexp_exp u_exp2 (.clk, .rate(c5), .x(x0), .exp_value(e2), .exp_sat(s2));

  logic v_d [ExpLat+1];
  logic [1:0] ic_d [ExpLat+1];
  assign v_d[0] = v0;
  assign ic_d[0] = ic0;
  for (genvar i = 0; i < ExpLat; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) v_d[i+1] <= 1'b0;
      else v_d[i+1] <= v_d[i];
      ic_d[i+1] <= ic_d[i];
    end
  end

  // Gain products.
  logic signed [47:0] g1, g2;
  logic vg, sg;
  logic [1:0] icg;
  always_ff @(posedge clk) begin
    if (rst) vg <= 1'b0;
    else vg <= v_d[ExpLat];
    g1 <= 48'(($signed(64'(c2)) * $signed(64'(e1))) >>> 16);
    g2 <= 48'(($signed(64'(c4)) * $signed(64'(e2))) >>> 16);
    sg <= s1 | s2;
    icg <= ic_d[ExpLat];
  end

  // Saturate terms and sum.
  logic signed [DataW-1:0] t1, t2;
  logic ts;
  logic signed [DataW+1:0] sum;
  always_comb begin
    ts = 1'b0;
    t1 = g1[DataW-1:0];
    t2 = g2[DataW-1:0];
    if (g1 > 48'(Q16Max)) begin t1 = Q16Max; ts = 1'b1; end
    if (g1 < 48'(Q16Min)) begin t1 = Q16Min; ts = 1'b1; end
    if (g2 > 48'(Q16Max)) begin t2 = Q16Max; ts = 1'b1; end
    if (g2 < 48'(Q16Min)) begin t2 = Q16Min; ts = 1'b1; end
    sum = 34'(c1) + 34'(t1) + 34'(t2);
  end

  logic vs, ss;
  logic [1:0] ics;
  logic signed [DataW-1:0] acc;
  always_ff @(posedge clk) begin
    if (rst) vs <= 1'b0;
    else vs <= vg;
    ics <= icg;
    ss <= sg | ts | (sum > 34'(Q16Max)) | (sum < 34'(Q16Min));
    if (sum > 34'(Q16Max)) acc <= Q16Max;
    else if (sum < 34'(Q16Min)) acc <= Q16Min;
    else acc <= sum[DataW-1:0];
  end

  // Output clamp.
  logic signed [DataW-1:0] lo_y, hi_y, y_lo;
  assign lo_y = output_limits[DataW-1:0];
  assign hi_y = output_limits[LimW-1:DataW];
  assign y_lo = (acc < lo_y) ? lo_y : acc;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vs;
    input_clamp <= ics;
    saturated <= ss;
    if (y_lo > hi_y) begin
      curve_value <= hi_y; output_clamp <= CLAMP_HIGH;
    end else begin
      curve_value <= y_lo;
      output_clamp <= (acc < lo_y) ? CLAMP_LOW : CLAMP_NONE;
    end
  end

`ifndef SYNTHESIS
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vs)) else $error("done without a word in flight");
  a_clamp_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (output_clamp != 2'd3 && input_clamp != 2'd3))
    else $error("bad clamp code");
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (done && output_clamp == CLAMP_HIGH) |-> curve_value == $past(hi_y))
    else $error("upper clamp value wrong");
`endif
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the double exponential curve evaluator.
`default_nettype none
module tb;
  import dexp_pkg::*;

  localparam int unsigned Latency = 39;
  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic signed [31:0] value;
    clamp_t in_clamp;
    clamp_t out_clamp;
    logic sat;
  } curve_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [31:0] x_sample = '0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [LimW-1:0] cfg_data = '0;
  logic busy, done, saturated;
  logic signed [31:0] curve_value;
  logic [1:0] input_clamp, output_clamp;

  logic signed [31:0] coef [1:5];
  logic signed [31:0] lo_x, hi_x;
  logic [63:0] limits;

  curve_word_t expected_words [$];
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  bit quiet = 1'b0;

  always #4 clk = ~clk;

  double_exponential_curve_eval_top i_dut (
    .clk, .rst, .start, .busy, .x_sample, .cfg_we, .cfg_index, .cfg_data,
    .done, .curve_value, .input_clamp, .output_clamp, .saturated
  );

  function automatic logic signed [63:0] sat_q16(input logic signed [63:0] v, inout bit flag);
    if (v > 64'sh7FFF_FFFF) begin
      flag = 1'b1;
      return 64'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      flag = 1'b1;
      return -64'sh8000_0000;
    end
    return v;
  endfunction

  function automatic logic signed [63:0] fixed_exp(input logic signed [63:0] a, inout bit flag);
    logic signed [127:0] prod;
    logic signed [63:0] u, k;
    logic [63:0] f, z, p;
    if (a > 64'sd2097152) begin
      flag = 1'b1;
      return 64'sh7FFF_FFFF;
    end
    if (a < -64'sd2097152) return 0;
    prod = a * 128'sd1549082005;
    u = prod >>> 30;
    k = u >>> 16;
    f = u & 64'hFFFF;
    z = (f * 64'd744261118) >> 16;
    p = 64'd1 << 30;
    for (int n = 9; n >= 1; n--) p = (64'd1 << 30) + ((z * p) >> 30) / n;
    if (k >= 15) begin
      flag = 1'b1;
      return 64'sh7FFF_FFFF;
    end
    if (k <= -48) return 0;
    return $signed(p >> (14 - k));
  endfunction

  function automatic logic signed [63:0] gain_term(input logic signed [31:0] g,
      input logic signed [31:0] r, input logic signed [63:0] x, inout bit flag);
    logic signed [63:0] a, e;
    logic signed [95:0] prod;
    a = (64'(r) * x) >>> 16;
    e = fixed_exp(a, flag);
    prod = 96'(g) * 96'(e);
    return sat_q16(64'(prod >>> 16), flag);
  endfunction

  function automatic curve_word_t predict_curve(input logic signed [31:0] x_in);
    curve_word_t w;
    logic signed [63:0] x, acc, lo_y, hi_y;
    bit flag;
    flag = 1'b0;
    x = x_in;
    w.in_clamp = CLAMP_NONE;
    w.out_clamp = CLAMP_NONE;
    if (x < lo_x) begin
      x = lo_x;
      w.in_clamp = CLAMP_LOW;
    end
    if (x > hi_x) begin
      x = hi_x;
      w.in_clamp = CLAMP_HIGH;
    end
    acc = 64'(coef[1]) + gain_term(coef[2], coef[3], x, flag)
        + gain_term(coef[4], coef[5], x, flag);
    acc = sat_q16(acc, flag);
    lo_y = $signed(limits[31:0]);
    hi_y = $signed(limits[63:32]);
    if (acc < lo_y) begin
      acc = lo_y;
      w.out_clamp = CLAMP_LOW;
    end
    if (acc > hi_y) begin
      acc = hi_y;
      w.out_clamp = CLAMP_HIGH;
    end
    w.value = acc[31:0];
    w.sat = flag;
    return w;
  endfunction

  // Result checker: every strobe must match the oldest expected word.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: value %0d", curve_value);
      end else begin
        curve_word_t exp_w;
        exp_w = expected_words.pop_front();
        if (curve_value !== exp_w.value || input_clamp !== exp_w.in_clamp
            || output_clamp !== exp_w.out_clamp || saturated !== exp_w.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     exp_w.value, exp_w.in_clamp, exp_w.out_clamp, exp_w.sat,
                     curve_value, input_clamp, output_clamp, saturated);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_C1: coef[1] = data[31:0];
      REG_C2: coef[2] = data[31:0];
      REG_C3: coef[3] = data[31:0];
      REG_C4: coef[4] = data[31:0];
      REG_C5: coef[5] = data[31:0];
      REG_X_MIN: lo_x = data[31:0];
      REG_X_MAX: hi_x = data[31:0];
      default: limits = data;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_word(input logic signed [31:0] x);
    if (!quiet)
      while ($urandom_range(99) < 14) begin
        start <= 1'b0;
        @(posedge clk);
      end
    start <= 1'b1;
    x_sample <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_words.push_back(predict_curve(x));
  endtask

  task automatic end_burst();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      3: return 32'h8000_0000 | $urandom_range(3);
      4: return 32'h7FFF_FFFF - $urandom_range(3);
      default: return $urandom_range(0, 32'h0000_2000) - 32'h0000_1000;
    endcase
  endfunction

  task automatic random_setting();
    logic signed [31:0] a, b;
    write_reg(REG_C1, {$urandom, rand_q16()});
    write_reg(REG_C2, {$urandom, rand_q16()});
    write_reg(REG_C3, {$urandom, rand_q16()});
    write_reg(REG_C4, {$urandom, rand_q16()});
    write_reg(REG_C5, {$urandom, rand_q16()});
    a = rand_q16();
    b = rand_q16();
    // Mostly ordered input limits, with crossed ones now and then.
    if ($urandom_range(4) != 0 && a > b) begin
      write_reg(REG_X_MIN, b);
      write_reg(REG_X_MAX, a);
    end else begin
      write_reg(REG_X_MIN, a);
      write_reg(REG_X_MAX, b);
    end
    case ($urandom_range(3))
      0: write_reg(REG_LIMITS, LimitsReset);
      1: write_reg(REG_LIMITS, {rand_q16(), rand_q16()});
      default: write_reg(REG_LIMITS, {$urandom, $urandom});
    endcase
  endtask

  task automatic test_reset_values();
    send_word(32'sh0000_8000);
    send_word(32'sh8000_0000);
    send_word(32'sh7FFF_FFFF);
    end_burst();
    drain();
  endtask

  task automatic test_directed();
    write_reg(REG_C1, 64'hFFFF_FFFF_0001_0000);
    write_reg(REG_C2, 32'h0002_0000);
    write_reg(REG_C3, 32'hFFFF_0000);
    write_reg(REG_C4, 32'h0000_8000);
    write_reg(REG_C5, 32'h0000_4000);
    write_reg(REG_X_MIN, 32'h8000_0000);
    write_reg(REG_X_MAX, 32'h7FFF_FFFF);
    write_reg(REG_LIMITS, LimitsReset);
    foreach (coef[i]) begin end
    send_word(0);
    send_word(32'sh0001_0000);
    send_word(32'shFFFF_0000);
    send_word(32'sh0020_0000);
    send_word(32'shFFE0_0000);
    send_word(32'sh8000_0000);
    send_word(32'sh7FFF_FFFF);
    end_burst();
    drain();
    // Exponential overflow with zero gain, crossed limits on both sides.
    write_reg(REG_C2, 0);
    write_reg(REG_C3, 32'h7FFF_FFFF);
    write_reg(REG_C4, 32'h7FFF_FFFF);
    write_reg(REG_C5, 32'h0010_0000);
    write_reg(REG_X_MIN, 32'h0002_0000);
    write_reg(REG_X_MAX, 32'hFFFF_0000);
    write_reg(REG_LIMITS, 64'h0000_1000_0010_0000);
    send_word(32'shFFFF_8000);
    send_word(32'sh0000_1000);
    send_word(32'sh0004_0000);
    end_burst();
    drain();
    write_reg(REG_C2, 32'h8000_0000);
    send_word(0);
    end_burst();
    drain();
    write_reg(REG_C3, 32'h8000_0000);
    write_reg(REG_X_MIN, 32'h8000_0000);
    write_reg(REG_X_MAX, 32'h7FFF_FFFF);
    write_reg(REG_LIMITS, 64'h0010_0000_FFF0_0000);
    send_word(32'sh7FFF_FFFF);
    send_word(32'sh8000_0000);
    send_word(32'sh0000_0001);
    send_word(32'shFFFF_FFFF);
    end_burst();
    drain();
  endtask

  task automatic test_random_settings();
    for (int s = 0; s < 20; s++) begin
      random_setting();
      quiet = (s == 7);
      for (int i = 0; i < 80; i++) begin
        logic signed [31:0] x;
        x = ($urandom_range(2) == 0) ? $urandom : rand_q16();
        send_word(x);
        // Once, in one setting, hold off until the pipeline is empty.
        if (i == 40 && s == 3) begin
          end_burst();
          drain();
        end
      end
      end_burst();
      drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    coef[1] = 0; coef[2] = 0; coef[3] = 0; coef[4] = 0; coef[5] = 0;
    lo_x = 0;
    hi_x = XMaxReset;
    limits = LimitsReset;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_directed();
    test_random_settings();
    repeat (Latency + 10) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
sv/dexp_pkg.sv
sv/dexp_exp.sv
sv/double_exponential_curve_eval_top.sv
sim/tb.sv
